// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the boundary marker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker package
// Field widths, configuration codes, reset values and the per-item control
// struct shared by the boundary marker modules.
// ----------------------------------------------------------------------------
package rbm_pkg;

    localparam int FRAME_W_BITS  = 11;
    localparam int FRAME_H_BITS  = 16;
    localparam int COLOR_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [FRAME_W_BITS-1:0]  FRAME_W_RESET = 11'd1024;
    localparam logic [FRAME_H_BITS-1:0]  FRAME_H_RESET = 16'd1024;
    localparam logic [COLOR_BITS-1:0]    MARK_RESET    = 32'h00FF_FFFF;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MARK_COLOR   = 2'd2
    } t_cfg_index;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic is_pixel;
        logic active;
        logic has_result;
        logic use_left;
        logic use_right;
        logic use_up;
        logic last;
    } t_item_ctl;

endpackage

// ===== rtl/core/rbm_in_if.sv =====
// ----------------------------------------------------------------------------
// Boundary marker input channel
// Valid/ready channel carrying one pixel or drain command per transaction.
// ----------------------------------------------------------------------------
interface rbm_in_if
    import rbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COLOR_BITS-1:0] pixel_color;

    modport source (output valid, output opcode, output pixel_color, input ready);
    modport sink   (input valid, input opcode, input pixel_color, output ready);
endinterface

// ===== rtl/core/rbm_out_if.sv =====
// ----------------------------------------------------------------------------
// Boundary marker output channel
// Valid/ready channel carrying one boundary map pixel per transaction.
// ----------------------------------------------------------------------------
interface rbm_out_if
    import rbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] edge_pixel;
    logic                  frame_done;

    modport source (output valid, output edge_pixel, output frame_done, input ready);
    modport sink   (input valid, input edge_pixel, input frame_done, output ready);
endinterface

// ===== rtl/core/rbm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic line store RAM
// One write port and one read port with registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module rbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Boundary marker control
// Configuration registers, column/row/drain counters and per-transaction
// control decode for the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbm_ctrl
    import rbm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_wdata,
    input  logic                          i_accept,
    input  logic                          i_opcode,
    output t_item_ctl                     o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x_next,
    output logic [COLOR_BITS-1:0]         o_mark_color
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > FRAME_W_BITS) ? CW : FRAME_W_BITS;

    logic [FRAME_W_BITS-1:0] r_frame_width;
    logic [FRAME_H_BITS-1:0] r_frame_height;
    logic [COLOR_BITS-1:0]   r_mark_color;

    logic [AW-1:0]           r_col, n_col;
    logic [FRAME_H_BITS-1:0] r_row, n_row;
    logic [AW-1:0]           r_dcol, n_dcol;
    logic                    r_drain_pending, n_drain_pending;

    logic [WW-1:0]           fw_ext;
    logic [WW-1:0]           eff_w;
    logic [FRAME_H_BITS-1:0] eff_h;
    logic                    is_pix;
    logic [AW-1:0]           idx;
    logic [WW-1:0]           x_inc;
    logic                    at_end;
    logic [FRAME_H_BITS:0]   y_inc;
    logic                    row_end;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_W_RESET;
            r_frame_height <= FRAME_H_RESET;
            r_mark_color   <= MARK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FRAME_W_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FRAME_H_BITS-1:0];
                CFG_MARK_COLOR:   r_mark_color   <= i_cfg_wdata[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective frame size: zero means one, width saturates at the store depth
    always_comb begin
        fw_ext = WW'(r_frame_width);
        if (fw_ext == '0) begin
            eff_w = WW'(1);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        eff_h = (r_frame_height == '0) ? FRAME_H_BITS'(1) : r_frame_height;
    end

    // column and row are already zero while a drain is pending
    always_comb begin
        is_pix  = (t_opcode'(i_opcode) == OP_PIXEL);
        idx     = is_pix ? r_col : r_dcol;
        x_inc   = WW'(idx) + WW'(1);
        at_end  = (x_inc >= eff_w);
        y_inc   = {1'b0, r_row} + (FRAME_H_BITS + 1)'(1);
        row_end = (y_inc >= {1'b0, eff_h});

        o_ctl.is_pixel   = is_pix;
        o_ctl.active     = is_pix || r_drain_pending;
        o_ctl.has_result = is_pix ? (r_row != '0) : r_drain_pending;
        o_ctl.use_left   = (idx != '0);
        o_ctl.use_right  = !at_end;
        o_ctl.use_up     = is_pix ? (r_row > FRAME_H_BITS'(1)) : (eff_h > FRAME_H_BITS'(1));
        o_ctl.last       = !is_pix && r_drain_pending && at_end;
    end

    assign o_x          = idx;
    assign o_x_next     = x_inc[AW-1:0];
    assign o_mark_color = r_mark_color;

    always_comb begin
        n_col           = r_col;
        n_row           = r_row;
        n_dcol          = r_dcol;
        n_drain_pending = r_drain_pending;
        if (i_accept) begin
            if (is_pix) begin
                // a pixel drops any pending drain
                n_drain_pending = 1'b0;
                n_dcol          = '0;
                if (at_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row           = '0;
                        n_drain_pending = 1'b1;
                        n_dcol          = '0;
                    end else begin
                        n_row = y_inc[FRAME_H_BITS-1:0];
                    end
                end else begin
                    n_col = x_inc[AW-1:0];
                end
            end else if (r_drain_pending) begin
                if (at_end) begin
                    n_drain_pending = 1'b0;
                    n_dcol          = '0;
                end else begin
                    n_dcol = x_inc[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col           <= '0;
            r_row           <= '0;
            r_dcol          <= '0;
            r_drain_pending <= 1'b0;
        end else begin
            r_col           <= n_col;
            r_row           <= n_row;
            r_dcol          <= n_dcol;
            r_drain_pending <= n_drain_pending;
        end
    end

    `RBM_ASSERT_IMPL(a_drain_at_origin, i_clk, i_rst_n, r_drain_pending, r_col == '0 && r_row == '0, "pixel counters not at origin during drain")
    `RBM_ASSERT_IMPL(a_drain_col_idle, i_clk, i_rst_n, r_dcol != '0, r_drain_pending, "drain column advanced without a pending drain")

endmodule

// ===== rtl/core/rbm_datapath.sv =====
// ----------------------------------------------------------------------------
// Boundary marker datapath
// Line stores, read stage with forwarding, neighbor compare and the output
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbm_datapath
    import rbm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [COLOR_BITS-1:0]         i_pixel_color,
    input  t_item_ctl                     i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x_next,
    input  logic [COLOR_BITS-1:0]         i_mark_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COLOR_BITS-1:0]         o_edge_pixel,
    output logic                          o_frame_done
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                  accept;
    logic                  s1_adv;

    logic                  r_s1_valid;
    t_item_ctl             r_s1_ctl;
    logic [AW-1:0]         r_s1_x;
    logic [COLOR_BITS-1:0] r_s1_pix;
    logic                  r_fwd;
    logic [COLOR_BITS-1:0] r_fwd_data;
    logic [COLOR_BITS-1:0] r_left;

    logic                  r_out_valid;
    logic [COLOR_BITS-1:0] r_out_edge;
    logic                  r_out_done;

    logic [COLOR_BITS-1:0] one_c;
    logic [COLOR_BITS-1:0] one_right;
    logic [COLOR_BITS-1:0] two_rd;
    logic [COLOR_BITS-1:0] up;
    logic                  diff;
    logic                  one_we;
    logic                  two_we;

    // an item without a result leaves the read stage regardless of the output
    assign s1_adv     = r_s1_valid && (!r_s1_ctl.has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    assign one_we = accept && i_ctl.is_pixel;
    assign two_we = s1_adv && r_s1_ctl.is_pixel;

    // row one up, replicated for the center and right-neighbor reads
    rbm_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_one_c (
        .i_clk   (i_clk),
        .i_we    (one_we),
        .i_waddr (i_x),
        .i_wdata (i_pixel_color),
        .i_re    (accept),
        .i_raddr (i_x),
        .o_rdata (one_c)
    );

    rbm_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_one_right (
        .i_clk   (i_clk),
        .i_we    (one_we),
        .i_waddr (i_x),
        .i_wdata (i_pixel_color),
        .i_re    (accept),
        .i_raddr (i_x_next),
        .o_rdata (one_right)
    );

    // row two up, written with the center value once it has been read
    rbm_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_two (
        .i_clk   (i_clk),
        .i_we    (two_we),
        .i_waddr (r_s1_x),
        .i_wdata (one_c),
        .i_re    (accept),
        .i_raddr (i_x),
        .o_rdata (two_rd)
    );

    assign up = r_fwd ? r_fwd_data : two_rd;

    always_comb begin
        diff = 1'b0;
        if (r_s1_ctl.use_left && (one_c != r_left)) begin
            diff = 1'b1;
        end
        if (r_s1_ctl.use_right && (one_c != one_right)) begin
            diff = 1'b1;
        end
        if (r_s1_ctl.use_up && (one_c != up)) begin
            diff = 1'b1;
        end
        if (r_s1_ctl.is_pixel && (one_c != r_s1_pix)) begin
            diff = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                // the row-two write of the leaving item lands on this edge: bypass it
                r_fwd      <= r_s1_valid && r_s1_ctl.is_pixel && (r_s1_x == i_x);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1_ctl.has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl   <= i_ctl;
            r_s1_x     <= i_x;
            r_s1_pix   <= i_pixel_color;
            r_fwd_data <= one_c;
        end
        if (s1_adv && r_s1_ctl.active) begin
            r_left <= one_c;
        end
        if (s1_adv && r_s1_ctl.has_result) begin
            r_out_edge <= diff ? i_mark_color : '0;
            r_out_done <= r_s1_ctl.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_edge_pixel = r_out_edge;
    assign o_frame_done = r_out_done;

    `RBM_ASSERT_IMPL(a_done_on_drain, i_clk, i_rst_n, r_s1_valid && r_s1_ctl.last, r_s1_ctl.has_result && !r_s1_ctl.is_pixel, "frame end flagged on a non-drain item")
    `RBM_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && r_s1_ctl.has_result && r_out_valid && !i_out_ready, r_s1_valid, "read stage dropped an item behind a full output")

endmodule

// ===== rtl/core/region_boundary_marker_top.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker
// Four-neighbor region boundary map over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one transaction per pixel in raster order (opcode pixel) or
//   one drain command (opcode drain). Each pixel of row y >= 1 returns the map
//   value of the pixel in the same column of row y-1; row 0 returns nothing.
//   After the frame's last pixel, each drain returns one pixel of the last
//   row; the final one has frame_done set. A drain with nothing pending
//   returns nothing, and a pixel during a drain starts a new frame.
//   o_res returns mark_color where a pixel differs from an existing
//   4-neighbor, else zero.
//   Configuration (width, height, mark color) is written on i_cfg_* while the
//   block is idle.
// Timing:
//   One transaction per cycle in steady state. The line stores are read on
//   the edge that takes a transaction into the read stage, and the compare
//   loads the output register from there when the read stage advances.
//   When o_res is stalled, one more transaction with a result waits in the
//   read stage; then i_pix.ready drops until the output register drains.
// Reset:
//   Synchronous, active low. Counters and pending drain clear, registers
//   return to their defaults; line stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module region_boundary_marker_top
    import rbm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rbm_in_if.sink                   i_pix,
    rbm_out_if.source                o_res,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                  in_ready;
    logic                  accept;
    t_item_ctl             ctl;
    logic [AW-1:0]         x;
    logic [AW-1:0]         x_next;
    logic [COLOR_BITS-1:0] mark_color;

    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    rbm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_opcode     (i_pix.opcode),
        .o_ctl        (ctl),
        .o_x          (x),
        .o_x_next     (x_next),
        .o_mark_color (mark_color)
    );

    rbm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_pix.valid),
        .o_in_ready    (in_ready),
        .i_pixel_color (i_pix.pixel_color),
        .i_ctl         (ctl),
        .i_x           (x),
        .i_x_next      (x_next),
        .i_mark_color  (mark_color),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_edge_pixel  (o_res.edge_pixel),
        .o_frame_done  (o_res.frame_done)
    );

endmodule
